/* hdl/iprc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprc_pkg
// shared types and constants of the predictive residual coder
// ----------------------------------------------------------------------------
package iprc_pkg;

   localparam int PIXEL_BITS      = 8;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;

   typedef logic [PIXEL_BITS-1:0]      pixel_type;
   typedef logic [WIDTH_REG_BITS-1:0]  width_reg_type;
   typedef logic [HEIGHT_REG_BITS-1:0] height_reg_type;
   typedef logic [CSR_DATA_BITS-1:0]   csr_data_type;
   typedef logic [CSR_INDEX_BITS-1:0]  csr_index_type;

   // register indexes
   localparam csr_index_type CSR_IMAGE_WIDTH  = 2'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 2'd1;

   localparam width_reg_type  IMAGE_WIDTH_RESET  = 11'd1024;
   localparam height_reg_type IMAGE_HEIGHT_RESET = 16'd1024;

   localparam pixel_type RESIDUAL_OFFSET = 8'd128;

   // raster position of one pixel
   typedef struct packed {
      logic first_row;
      logic first_col;
   } position_type;

endpackage
`default_nettype wire

/* hdl/iprc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprc stream interfaces
// valid/ready channels for pixel beats and residual beats
// ----------------------------------------------------------------------------
interface iprc_req_if;
   logic                     valid;
   logic                     ready;
   iprc_pkg::pixel_type      pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface iprc_rsp_if;
   logic                     valid;
   logic                     ready;
   iprc_pkg::pixel_type      residual;
   iprc_pkg::pixel_type      prediction;
   logic                     end_of_frame;

   modport source (output valid, output residual, output prediction,
                   output end_of_frame, input ready);
   modport sink   (input valid, input residual, input prediction,
                   input end_of_frame, output ready);
endinterface
`default_nettype wire

/* hdl/image_predictive_residual_coder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_predictive_residual_coder_top
// dpcm coder for raster grey pixels with a one row line buffer
// ----------------------------------------------------------------------------
// path: an accepted beat passes the compute stage, then the output register
// throughput: one pixel per cycle without residual back-pressure, set by the
//   line buffer ram (one read, one write port, both used on every accepted beat)
// reset: counters, neighbors and valids clear at once; the line buffer is not
//   cleared; below row 0 only a row widened mid-frame gets unwritten columns read
// ----------------------------------------------------------------------------
module image_predictive_residual_coder_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   iprc_req_if.sink                     req_stream,
   iprc_rsp_if.source                   rsp_stream,
   input  wire logic                    csr_write_enable,
   input  wire iprc_pkg::csr_index_type csr_index,
   input  wire iprc_pkg::csr_data_type  csr_write_data
);
   import iprc_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   // compare width for column position against the row length
   localparam int CMP_BITS = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;
   localparam int ROW_CMP_BITS = HEIGHT_REG_BITS + 1;

   // configuration
   width_reg_type  image_width_ff;
   height_reg_type image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size: zero means one, width saturates at the buffer size
   logic [CMP_BITS-1:0]     eff_width;
   logic [ROW_CMP_BITS-1:0] eff_height;

   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = CMP_BITS'(1);
      end else if (CMP_BITS'(image_width_ff) > CMP_BITS'(MAX_WIDTH)) begin
         eff_width = CMP_BITS'(MAX_WIDTH);
      end else begin
         eff_width = CMP_BITS'(image_width_ff);
      end
      eff_height = (image_height_ff == '0) ? ROW_CMP_BITS'(1) : {1'b0, image_height_ff};
   end

   // handshake and pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic s1_move;
   logic req_fire;

   assign out_free = !out_valid_ff || rsp_stream.ready;
   assign s1_move  = s1_valid_ff && out_free;
   // take a new beat whenever the compute stage is empty or draining
   assign req_stream.ready = !s1_valid_ff || out_free;
   assign req_fire = req_stream.valid && req_stream.ready;

   // raster counters
   logic [COL_BITS-1:0]        col_ff, col_in;
   logic [HEIGHT_REG_BITS-1:0] row_ff, row_in;
   logic [CMP_BITS-1:0]        col_next;
   logic [ROW_CMP_BITS-1:0]    row_next;
   logic                       end_of_row;
   logic                       end_of_frame;

   always_comb begin
      col_next     = CMP_BITS'(col_ff) + CMP_BITS'(1);
      row_next     = {1'b0, row_ff} + ROW_CMP_BITS'(1);
      end_of_row   = col_next >= eff_width;
      end_of_frame = end_of_row && (row_next >= eff_height);

      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (end_of_row) begin
            col_in = '0;
            row_in = end_of_frame ? '0 : row_next[HEIGHT_REG_BITS-1:0];
         end else begin
            col_in = col_next[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffer: the current pixel overwrites its column while the old
   // value of that column is read out as the pixel above
   pixel_type ram_rd_data;

   iprc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (req_stream.pixel),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // compute stage
   pixel_type    s1_pixel_ff;
   position_type s1_pos_ff;
   logic         s1_eof_ff;
   logic         s1_fresh_ff;     // ram data is for this beat this cycle
   pixel_type    s1_above_ff;     // above value held across a stall
   pixel_type    above_raw;
   pixel_type    above;
   pixel_type    left_ff;
   pixel_type    upper_left_ff;
   pixel_type    prediction;
   pixel_type    residual;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);
   assign above_raw   = s1_fresh_ff ? ram_rd_data : s1_above_ff;
   // the first row has nothing above it
   assign above       = s1_pos_ff.first_row ? '0 : above_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fresh_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_fresh_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_above_ff <= above_raw;
      if (req_fire) begin
         s1_pixel_ff         <= req_stream.pixel;
         s1_pos_ff.first_row <= row_ff == '0;
         s1_pos_ff.first_col <= col_ff == '0;
         s1_eof_ff           <= end_of_frame;
      end
   end

   // neighbors advance when a beat leaves the compute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else if (s1_move) begin
         left_ff       <= s1_pixel_ff;
         upper_left_ff <= above;
      end
   end

   iprc_predictor u_predictor (
      .pixel      (s1_pixel_ff),
      .above      (above),
      .left       (left_ff),
      .upper_left (upper_left_ff),
      .pos        (s1_pos_ff),
      .prediction (prediction),
      .residual   (residual)
   );

   // output register
   pixel_type out_residual_ff;
   pixel_type out_prediction_ff;
   logic      out_eof_ff;

   assign out_valid_in = s1_move || (out_valid_ff && !rsp_stream.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_residual_ff   <= residual;
         out_prediction_ff <= prediction;
         out_eof_ff        <= s1_eof_ff;
      end
   end

   assign rsp_stream.valid        = out_valid_ff;
   assign rsp_stream.residual     = out_residual_ff;
   assign rsp_stream.prediction   = out_prediction_ff;
   assign rsp_stream.end_of_frame = out_eof_ff;

`ifndef SYNTH
   // an accepted beat always lands in the compute stage
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted beat did not reach compute stage");

   // ram data is only marked fresh right after a read
   a_fresh_after_read: assert property (@(posedge clock) disable iff (reset)
      s1_fresh_ff |-> $past(req_fire))
      else $error("fresh ram data without a read");

   // a stalled compute stage keeps its beat
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_pixel_ff)))
      else $error("compute stage lost a stalled beat");

   // the last pixel of a frame returns the counters to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && end_of_frame) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not wrap at end of frame");
`endif

endmodule
`default_nettype wire

/* hdl/iprc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprc_ram
// generic simple dual port ram, registered read, old data on collision
// ----------------------------------------------------------------------------
module iprc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hdl/iprc_predictor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprc_predictor
// neighbor based prediction and wrapped residual for one pixel
// ----------------------------------------------------------------------------
module iprc_predictor (
   input  wire iprc_pkg::pixel_type    pixel,
   input  wire iprc_pkg::pixel_type    above,
   input  wire iprc_pkg::pixel_type    left,
   input  wire iprc_pkg::pixel_type    upper_left,
   input  wire iprc_pkg::position_type pos,
   output iprc_pkg::pixel_type         prediction,
   output iprc_pkg::pixel_type         residual
);
   import iprc_pkg::*;

   logic [9:0]         pair_sum;
   logic [10:0]        triple_sum;
   logic signed [11:0] num;
   logic signed [11:0] biased;

   always_comb begin
      pair_sum   = {2'b00, above} + {2'b00, left};
      triple_sum = {1'b0, pair_sum} + {pair_sum, 1'b0};
      num        = $signed({1'b0, triple_sum}) - $signed({3'b000, upper_left, 1'b0});
      // truncate toward zero: bias negatives before the shift
      biased     = num + (num[11] ? 12'sd3 : 12'sd0);

      if (pos.first_row && pos.first_col) begin
         prediction = pixel;
      end else if (pos.first_col) begin
         prediction = above;
      end else if (pos.first_row) begin
         prediction = left;
      end else begin
         prediction = biased[9:2];
      end

      residual = pixel - prediction + RESIDUAL_OFFSET;
   end

endmodule
`default_nettype wire

/* bench/iprc_residual_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_residual_checker
// watches the pixel, residual and csr ports of the coder, predicts every
// residual beat from its own copy of the line buffer, neighbors and raster
// counters, and compares the residual beats in order
// ----------------------------------------------------------------------------
module iprc_residual_checker #(
   parameter int LINE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   iprc_req_if                     pixel_bus,
   iprc_rsp_if                     residual_bus,
   input  logic                    csr_write_enable,
   input  iprc_pkg::csr_index_type csr_index,
   input  iprc_pkg::csr_data_type  csr_write_data,
   output int                      fail_count,
   output int                      open_count
);
   import iprc_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      pixel_type residual;
      pixel_type prediction;
      logic      end_of_frame;
   } residual_beat_type;

   residual_beat_type expected_residuals[$];

   pixel_type      line_mem [0:LINE_DEPTH-1];
   width_reg_type  width_reg;
   height_reg_type height_reg;
   pixel_type      left_px;
   pixel_type      upleft_px;
   int unsigned    col_cnt;
   int unsigned    row_cnt;

   // code one pixel and move the raster position on
   function automatic residual_beat_type code_pixel(pixel_type px);
      residual_beat_type beat;
      int unsigned       row_len;
      int unsigned       rows;
      int unsigned       col;
      pixel_type         above;
      pixel_type         pred;
      int                weighted;
      logic              row_end;

      row_len = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
      rows    = (height_reg == 0) ? 1 : height_reg;
      col     = col_cnt % LINE_DEPTH;
      above   = (row_cnt != 0) ? line_mem[col] : '0;

      if (row_cnt == 0 && col == 0) begin
         pred = px;
      end else if (col == 0) begin
         pred = above;
      end else if (row_cnt == 0) begin
         pred = left_px;
      end else begin
         // signed division truncates toward zero
         weighted = 3 * (int'(above) + int'(left_px)) - 2 * int'(upleft_px);
         pred     = pixel_type'(weighted / 4);
      end

      row_end                 = (col_cnt + 1 >= row_len);
      beat.residual           = px - pred + RESIDUAL_OFFSET;
      beat.prediction         = pred;
      beat.end_of_frame       = row_end && (row_cnt + 1 >= rows);

      line_mem[col] = px;
      upleft_px     = above;
      left_px       = px;
      if (row_end) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1 >= rows) ? 0 : ((row_cnt + 1) & 16'hFFFF);
      end else begin
         col_cnt = col_cnt + 1;
      end
      return beat;
   endfunction

   always @(posedge clock) begin
      residual_beat_type got;
      residual_beat_type want;
      if (reset) begin
         width_reg  = IMAGE_WIDTH_RESET;
         height_reg = IMAGE_HEIGHT_RESET;
         left_px    = '0;
         upleft_px  = '0;
         col_cnt    = 0;
         row_cnt    = 0;
         fail_count = 0;
         expected_residuals.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_reg = csr_write_data[WIDTH_REG_BITS-1:0];
               end
               CSR_IMAGE_HEIGHT: begin
                  height_reg = csr_write_data[HEIGHT_REG_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (pixel_bus.valid && pixel_bus.ready)
            expected_residuals.push_back(code_pixel(pixel_bus.pixel));
         if (residual_bus.valid && residual_bus.ready) begin
            got = '{residual_bus.residual, residual_bus.prediction, residual_bus.end_of_frame};
            if (expected_residuals.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: residual beat with no pixel pending: res %0d pred %0d eof %0b",
                           $realtime, got.residual, got.prediction, got.end_of_frame);
            end else begin
               want = expected_residuals.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"%0t: residual mismatch: expected res %0d pred %0d eof %0b,",
                               " got res %0d pred %0d eof %0b"}, $realtime,
                              want.residual, want.prediction, want.end_of_frame,
                              got.residual, got.prediction, got.end_of_frame);
               end
            end
         end
      end
      open_count <= expected_residuals.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives pixel beats and csr writes into the predictive residual coder with
// random gaps and residual back-pressure; the residual checker beside the
// block predicts and compares every residual beat, this module gives the verdict
// ----------------------------------------------------------------------------
module testbench;
   import iprc_pkg::*;

   localparam int          LINE_DEPTH  = 1024;
   localparam int          HOLD_CYCLES = 300;      // long residual hold-off
   localparam int          RANDOM_GOAL = 880;      // random pixel beats after the directed part
   localparam int unsigned CYCLE_LIMIT = 600000;

   // indexes with no register behind them, written to check they are ignored
   localparam csr_index_type CSR_UNMAPPED_2 = 2'd2;
   localparam csr_index_type CSR_UNMAPPED_3 = 2'd3;

   // corner sequence for a 3x3 frame, sent first pixel first from the top byte
   localparam logic [71:0] CORNER_PIXELS = {8'd7, 8'd0, 8'd255, 8'd255, 8'd0,
                                            8'd255, 8'd0, 8'd0, 8'd255};

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;
   int            fail_count;
   int            open_count;

   // handshake knobs for the sender and the receiver
   bit            hold_rsp    = 1'b0;
   bit            rsp_free    = 1'b1;
   bit            sender_free = 1'b1;

   // raster position as the block sees it, kept to avoid reading an
   // unwritten line buffer entry when the row width is raised mid-frame
   width_reg_type  size_w      = IMAGE_WIDTH_RESET;
   height_reg_type size_h      = IMAGE_HEIGHT_RESET;
   int unsigned    col_pos     = 0;
   int unsigned    row_pos     = 0;
   int unsigned    filled_cols = 0;   // line buffer columns written so far
   int unsigned    pixels_sent = 0;
   int unsigned    cycle_count = 0;

   iprc_req_if pixel_bus ();
   iprc_rsp_if residual_bus ();

   image_predictive_residual_coder_top #(
      .MAX_WIDTH(LINE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (pixel_bus),
      .rsp_stream       (residual_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   iprc_residual_checker #(
      .LINE_DEPTH(LINE_DEPTH)
   ) residual_checker (
      .clock            (clock),
      .reset            (reset),
      .pixel_bus        (pixel_bus),
      .residual_bus     (residual_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .open_count       (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("image_predictive_residual_coder_top verification failed");
         $finish;
      end
   end

   // mostly short stalls, now and then a long one; never zero
   function automatic int unsigned stall_cycles();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(6, 40);
   endfunction

   // row length the block actually uses for a width register value
   function automatic int unsigned eff_width(width_reg_type raw);
      if (raw == 0)
         return 1;
      if (raw > LINE_DEPTH)
         return LINE_DEPTH;
      return 32'(raw);
   endfunction

   // pixel content: uniform noise, hard black/white, a noisy ramp, or mid-grey
   function automatic pixel_type next_pixel(int content, int unsigned idx);
      case (content)
         1:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         2:       return pixel_type'(idx * 3 + $urandom_range(0, 4));
         3:       return pixel_type'(120 + $urandom_range(0, 16));
         default: return pixel_type'($urandom);
      endcase
   endfunction

   // residual side: free running, random stalls, or one long hold-off
   initial begin
      forever begin
         if (hold_rsp) begin
            residual_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!rsp_free && $urandom_range(0, 99) < 25) begin
            residual_bus.ready <= 1'b0;
            repeat (stall_cycles()) @(posedge clock);
         end else begin
            residual_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one pixel beat and hold it until accepted; valid stays high
   task automatic send_pixel(input pixel_type px);
      int unsigned row_len;
      int unsigned rows;
      pixel_bus.valid <= 1'b1;
      pixel_bus.pixel <= px;
      do @(posedge clock); while (!pixel_bus.ready);
      pixels_sent++;
      // follow the raster position the same way the block wraps it
      row_len = eff_width(size_w);
      rows    = (size_h == 0) ? 1 : size_h;
      if (col_pos % LINE_DEPTH + 1 > filled_cols)
         filled_cols = col_pos % LINE_DEPTH + 1;
      if (col_pos + 1 >= row_len) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= rows) ? 0 : ((row_pos + 1) & 16'hFFFF);
      end else begin
         col_pos++;
      end
   endtask

   // a burst of pixels with random sender gaps unless the sender is free running
   task automatic run_pixels(input int unsigned count, input int content);
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(next_pixel(content, i));
         if (!sender_free && $urandom_range(0, 99) < 30) begin
            pixel_bus.valid <= 1'b0;
            repeat (stall_cycles()) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait until every residual beat has come back
   task automatic wait_drained();
      pixel_bus.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   // one csr write; enable stays high when another write follows at once
   task automatic write_reg(input csr_index_type idx, input csr_data_type value,
                            input bit last);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      if (last)
         csr_write_enable <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         size_w = value[WIDTH_REG_BITS-1:0];
      else if (idx == CSR_IMAGE_HEIGHT)
         size_h = value[HEIGHT_REG_BITS-1:0];
   endtask

   // random frame size, mostly small, with the extremes mixed in
   task automatic pick_size();
      csr_data_type w_data;
      csr_data_type h_data;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 65)
         w_data = csr_data_type'($urandom_range(1, 8));
      else if (r < 88)
         w_data = csr_data_type'($urandom_range(9, 48));
      else if (r < 93)
         w_data = '0;
      else
         w_data = csr_data_type'($urandom_range(1000, 2047));
      // bits above the width register are ignored by the block
      w_data[15:11] = 5'($urandom);
      // below the first row, a wider row would read columns never written
      if (row_pos != 0 && eff_width(w_data[WIDTH_REG_BITS-1:0]) > filled_cols)
         w_data = csr_data_type'(filled_cols);

      r = $urandom_range(0, 99);
      if (r < 60)
         h_data = csr_data_type'($urandom_range(1, 6));
      else if (r < 88)
         h_data = csr_data_type'($urandom_range(7, 64));
      else if (r < 93)
         h_data = '0;
      else if (r < 97)
         h_data = 16'hFFFF;
      else
         h_data = csr_data_type'($urandom);

      if ($urandom_range(0, 9) == 0)
         write_reg(($urandom_range(0, 1) != 0) ? CSR_UNMAPPED_2 : CSR_UNMAPPED_3,
                   csr_data_type'($urandom), 1'b0);
      case ($urandom_range(0, 3))
         0: begin
            write_reg(CSR_IMAGE_WIDTH, w_data, 1'b1);
         end
         1: begin
            write_reg(CSR_IMAGE_HEIGHT, h_data, 1'b1);
         end
         default: begin
            write_reg(CSR_IMAGE_WIDTH, w_data, 1'b0);
            write_reg(CSR_IMAGE_HEIGHT, h_data, 1'b1);
         end
      endcase
   endtask

   initial begin
      int unsigned random_goal;
      int unsigned segment;

      pixel_bus.valid  <= 1'b0;
      pixel_bus.pixel  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // reset size: first pixel predicts itself, the rest of row 0 uses left
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd128);

      // shrink to 3x3 mid-row: the column count is already past the new end,
      // so the next pixel closes the row; then above, left and the weighted
      // blend with a negative sum, and the frame end
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, 16'hF803, 1'b0);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3, 1'b1);
      for (int i = 0; i < 9; i++)
         send_pixel(CORNER_PIXELS[71 - 8 * i -: 8]);

      // zero width and height act as one: every pixel ends the frame
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, 16'd0, 1'b0);
      write_reg(CSR_IMAGE_HEIGHT, 16'd0, 1'b1);
      send_pixel(8'd1);
      send_pixel(8'd254);
      send_pixel(8'd128);

      // width beyond the line buffer saturates, tallest frame
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, 16'h07FF, 1'b0);
      write_reg(CSR_IMAGE_HEIGHT, 16'hFFFF, 1'b1);
      send_pixel(8'd200);
      send_pixel(8'd13);

      // writes to unmapped indexes change nothing
      wait_drained();
      write_reg(CSR_UNMAPPED_2, csr_data_type'($urandom), 1'b0);
      write_reg(CSR_UNMAPPED_3, csr_data_type'($urandom), 1'b1);
      send_pixel(8'd77);
      send_pixel(8'd178);

      // ---- random part ----
      random_goal = pixels_sent + RANDOM_GOAL;
      segment     = 0;
      while (pixels_sent < random_goal) begin
         if (segment == 2) begin
            // residual side holds off for a long stretch while pixels keep
            // coming, so the pipeline fills and back-pressures the pixel side
            sender_free = 1'b1;
            hold_rsp    = 1'b1;
            run_pixels(24, 0);
         end else begin
            if ($urandom_range(0, 9) < 6) begin
               wait_drained();
               pick_size();
            end
            // some segments run with no idling at all on one or both sides
            sender_free = ($urandom_range(0, 4) == 0);
            rsp_free    = ($urandom_range(0, 4) == 0);
            run_pixels($urandom_range(10, 60), $urandom_range(0, 3));
         end
         segment++;
      end

      // ---- wind down ----
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("image_predictive_residual_coder_top verification clean");
      else
         $display("image_predictive_residual_coder_top verification failed");
      $finish;
   end

endmodule
